// ----- hdl/hsti_pkg.sv -----
// ----------------------------------------------------------------------------
// hsti_pkg
// Character codes and the character class record shared by the hex string
// parser modules.
// ----------------------------------------------------------------------------
package hsti_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;

	// low nibble of 'A'/'a' is 1, so letter value = nibble + 9
	localparam logic [3:0] LETTER_OFS = 4'd9;

	typedef struct packed {
		logic       is_zero;
		logic       is_blank;
		logic       is_sign;
		logic       is_minus;
		logic       is_hex;
		logic [3:0] digit;
	} char_class_t;

endpackage

// ----- hdl/hex_string_to_signed_int.sv -----
// ----------------------------------------------------------------------------
// hex_string_to_signed_int
// Parses a hex number (optional sign, leading blanks) from a byte stream and
// emits it as a signed 32-bit value on the string's last character.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall   char_code[7:0], last_char
//  out      output     out_valid / out_stall parsed_value[31:0] (signed)
//
//  One character per cycle while in_stall is low; once its last character
//  is taken, a string's value passes the input and then the result register.
//  Only the last character needs the result register; others pass freely.
//  in_stall rises only while a finished value waits on a stalled output and
//  the next character is also a last one.
//  arst_n clears all control and parse state; payload registers are not reset.
// ----------------------------------------------------------------------------
module hex_string_to_signed_int (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] parsed_value
);
	import hsti_pkg::*;

	logic        vld_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	logic        adv_s1;
	logic        step;
	logic [31:0] result;
	char_class_t cls;

	logic        vld_s2;
	logic [31:0] value_s2;

	// a non-final character never needs the result slot
	assign adv_s1   = !vld_s1 || !last_s1 || !vld_s2 || !out_stall;
	assign in_stall = !adv_s1;
	assign step     = vld_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	hsti_char_class u_cls (
		.char_code (char_s1),
		.cls       (cls)
	);

	hsti_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cls    (cls),
		.last   (last_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step && last_s1) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			value_s2 <= result;
		end
	end

	assign out_valid    = vld_s2;
	assign parsed_value = value_s2;

endmodule

// ----- hdl/hsti_char_class.sv -----
// ----------------------------------------------------------------------------
// hsti_char_class
// Decodes one ASCII byte into the classes the parser acts on.
// ----------------------------------------------------------------------------
module hsti_char_class (
	input  logic [7:0]           char_code,
	output hsti_pkg::char_class_t cls
);
	import hsti_pkg::*;

	logic is_dec;
	logic is_uc;
	logic is_lc;

	always_comb begin
		is_dec = (char_code >= CH_0) && (char_code <= CH_9);
		is_uc  = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);
		is_lc  = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);

		cls.is_zero  = (char_code == CH_NUL);
		cls.is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
			(char_code == CH_LF);
		cls.is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		cls.is_minus = (char_code == CH_MINUS);
		cls.is_hex   = is_dec || is_uc || is_lc;
		cls.digit    = is_dec ? char_code[3:0] : (char_code[3:0] + LETTER_OFS);
	end

endmodule

// ----- hdl/hsti_parser.sv -----
// ----------------------------------------------------------------------------
// hsti_parser
// Parse state: started / sign / finished flags and the 32-bit accumulator.
// Updates once per stepped character and presents the signed result for the
// final character of a string.
// ----------------------------------------------------------------------------
module hsti_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hsti_pkg::char_class_t cls,
	input  logic                  last,
	output logic [31:0]           result
);
	import hsti_pkg::*;

	logic        started_q;
	logic        neg_q;
	logic        fin_q;
	logic [31:0] acc_q;

	logic        started_d;
	logic        neg_d;
	logic        fin_d;
	logic [31:0] acc_d;

	always_comb begin
		started_d = started_q;
		neg_d     = neg_q;
		fin_d     = fin_q;
		acc_d     = acc_q;
		if (!fin_q) begin
			if (cls.is_zero) begin
				fin_d = 1'b1;
			end else if (cls.is_blank) begin
				fin_d = started_q;
			end else if (cls.is_sign) begin
				if (started_q) begin
					fin_d = 1'b1;
				end else begin
					started_d = 1'b1;
					neg_d     = cls.is_minus;
				end
			end else if (cls.is_hex) begin
				started_d = 1'b1;
				acc_d     = {acc_q[27:0], cls.digit};
			end
		end
		result = neg_d ? (~acc_d + 32'd1) : acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			neg_q     <= 1'b0;
			fin_q     <= 1'b0;
			acc_q     <= '0;
		end else if (step) begin
			if (last) begin
				started_q <= 1'b0;
				neg_q     <= 1'b0;
				fin_q     <= 1'b0;
				acc_q     <= '0;
			end else begin
				started_q <= started_d;
				neg_q     <= neg_d;
				fin_q     <= fin_d;
				acc_q     <= acc_d;
			end
		end
	end

endmodule

// ----- hdl/hsti_checker.sv -----
// ----------------------------------------------------------------------------
// hsti_checker
// Port-level checks for hex_string_to_signed_int, bound to the top level.
// ----------------------------------------------------------------------------
module hsti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         char_code,
	input logic               last_char,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] parsed_value
);

	// a stalled input transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled input changed or dropped");

	// a stalled result transaction holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parsed_value))
		else $error("stalled result changed or dropped");

	// input backpressure only while a finished value is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// a result leaves only by being taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

endmodule

bind hex_string_to_signed_int hsti_checker u_hsti_checker (.*);
